FILE: sv/sct_pkg.sv
// Package for the sparse coordinate table: sizes, codes and transaction types.
package sct_pkg;

	// Table and grid sizes.
	localparam int CAPACITY   = 32;
	localparam int GRID_SIDE  = 8;
	localparam int LABEL_BITS = 16;

	// Derived widths.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CRD_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int LBL_W = (LABEL_BITS < 16) ? LABEL_BITS : 16;

	// Request modes; the fourth code behaves as a get.
	localparam logic [1:0] MODE_SET    = 2'd0;
	localparam logic [1:0] MODE_GET    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_PLACED  = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_REMOVED = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_RANGE   = 3'd5;
	localparam logic [2:0] ST_READ    = 3'd6;

	// One request transaction.
	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  row;
		logic [3:0]  column;
		logic [15:0] piece_label;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [15:0] label_out;
		logic [5:0]  entry_count;
	} rsp_t;

	// One stored table entry.
	typedef struct packed {
		logic [CRD_W-1:0] row;
		logic [CRD_W-1:0] column;
		logic [LBL_W-1:0] label;
	} entry_t;

	// Status from the sequencer to the top level.
	typedef struct packed {
		logic busy;
		logic fin;
	} ctl_t;

endpackage

FILE: sv/sct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/sct_ctrl.sv
// Sequencer that scans, updates and compacts the entry RAM one entry per cycle.
module sct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sct_pkg::req_t request,
	output sct_pkg::ctl_t ctl,
	output sct_pkg::rsp_t rsp
);
	import sct_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;

	logic [1:0]       state_q, state_d;
	req_t             req_q, cur;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] ptr_q, ptr_d, ptr_nxt, ptr_prv;
	logic [LBL_W-1:0] cur_lab;
	logic             in_range, is_set, is_del, last, match, hit, decide, fin;
	entry_t           rdata, wdata;
	logic             we;
	logic [IDX_W-1:0] waddr, raddr;

	// Entry store.
	sct_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// The live request is used in the accepting cycle, the held copy afterwards.
	assign cur      = (state_q == S_IDLE) ? request : req_q;
	assign cur_lab  = cur.piece_label[LBL_W-1:0];
	assign in_range = (32'(cur.row) < GRID_SIDE) && (32'(cur.column) < GRID_SIDE);
	assign is_set   = (cur.mode == MODE_SET) && (cur_lab != '0);
	assign is_del   = (cur.mode == MODE_SET) || (cur.mode == MODE_REMOVE);

	// Shared coordinate comparator and scan pointer arithmetic.
	assign ptr_nxt = ptr_q + CNT_W'(1);
	assign ptr_prv = ptr_q - CNT_W'(1);
	assign last    = (ptr_nxt == count_q);
	assign match   = (rdata.row == CRD_W'(cur.row)) && (rdata.column == CRD_W'(cur.column));

	// Next-state, RAM access and result logic.
	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		count_d      = count_q;
		we           = 1'b0;
		waddr        = ptr_q[IDX_W-1:0];
		wdata.row    = CRD_W'(cur.row);
		wdata.column = CRD_W'(cur.column);
		wdata.label  = cur_lab;
		raddr        = ptr_nxt[IDX_W-1:0];
		fin          = 1'b0;
		decide       = 1'b0;
		hit          = 1'b0;
		rsp          = '0;

		unique case (state_q)
			S_IDLE: begin
				raddr = '0;
				ptr_d = '0;
				if (start) begin
					if (!in_range) begin
						fin        = 1'b1;
						rsp.status = ST_RANGE;
					end else if (count_q == '0) begin
						decide = 1'b1;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				ptr_d = ptr_nxt;
				if (match || last) begin
					decide  = 1'b1;
					hit     = match;
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				// Move the entry read last cycle down by one place.
				we    = 1'b1;
				waddr = ptr_prv[IDX_W-1:0];
				wdata = rdata;
				ptr_d = ptr_nxt;
				if (last) begin
					fin        = 1'b1;
					rsp.status = ST_REMOVED;
					rsp.found  = 1'b1;
					count_d    = count_q - CNT_W'(1);
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Outcome once the scan has found the cell or run out of entries, or at once on an empty table.
		if (decide) begin
			fin       = 1'b1;
			rsp.found = hit;
			if (is_set) begin
				if (hit) begin
					we         = 1'b1;
					waddr      = ptr_q[IDX_W-1:0];
					rsp.status = ST_UPDATED;
				end else if (count_q >= CNT_W'(CAPACITY)) begin
					rsp.status = ST_FULL;
				end else begin
					we         = 1'b1;
					waddr      = count_q[IDX_W-1:0];
					count_d    = count_q + CNT_W'(1);
					rsp.status = ST_PLACED;
				end
			end else if (is_del) begin
				if (!hit) begin
					rsp.status = ST_EMPTY;
				end else if (last) begin
					count_d    = count_q - CNT_W'(1);
					rsp.status = ST_REMOVED;
				end else begin
					fin     = 1'b0;
					state_d = S_SHIFT;
				end
			end else begin
				rsp.status = ST_READ;
				if (hit) begin
					rsp.label_out = 16'(rdata.label);
				end
			end
		end

		rsp.entry_count = 6'(count_d);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			count_q <= count_d;
		end
	end

	// Hold the request for the rest of the transaction.
	always_ff @(posedge clk) begin
		if (start && (state_q == S_IDLE)) begin
			req_q <= request;
		end
	end

	assign ctl.busy = (state_q != S_IDLE);
	assign ctl.fin  = fin;

endmodule

FILE: sv/sparse_coordinate_table_core.sv
// Top level of the sparse coordinate table: sequencer plus the result register.
// A request is taken on a clock edge with start high and busy low. A request
// with an out-of-range cell, or one that meets an empty table, needs no scan;
// otherwise the block is busy while it reads the entry RAM one entry per cycle
// through its single read port until the cell is found or the entries run out,
// and a removal then moves each later entry down one place, again one per
// cycle. The scan and the shift together visit each stored entry at most once,
// and a new request can be taken in the cycle busy falls. The result appears
// with done high for exactly one cycle, the cycle after the request finishes.
// The receiver cannot stall: it must take each result in the cycle it is
// shown.
module sparse_coordinate_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sct_pkg::req_t request,
	output logic          busy,
	output logic          done,
	output sct_pkg::rsp_t result
);
	import sct_pkg::*;

	ctl_t ctl;
	rsp_t rsp;
	logic done_q;
	rsp_t result_q;

	// Sequencer with its entry RAM.
	sct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.ctl    (ctl),
		.rsp    (rsp)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			result_q <= rsp;
		end
	end

	assign busy   = ctl.busy;
	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: sv/sct_checker.sv
// Port-level checker for the sparse coordinate table, bound to the top level.
module sct_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input sct_pkg::req_t request,
	input logic          busy,
	input logic          done,
	input sct_pkg::rsp_t result
);
	import sct_pkg::*;

	// An accepted transaction either starts a scan or finishes right away.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither busy nor done");

	// The end of a scan always shows a result.
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// A result is shown only while the block is ready again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// The entry count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.entry_count) <= CAPACITY))
		else $error("entry count above capacity");

	// Only a read returns a label, and a range error never reports a hit.
	a_label_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_READ)) |->
		((result.label_out == '0) && !((result.status == ST_RANGE) && result.found)))
		else $error("label or hit on a non-read result");

endmodule

bind sparse_coordinate_table_core sct_checker u_sct_checker (.*);
